// ----- rtl/bfp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the best-fit buffer pool.
// No dependencies.
package bfp_pkg;

    localparam int ENTRIES   = 64;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int CNT_W     = $clog2(ENTRIES + 1);
    localparam int MEM_W     = 38;
    localparam logic [31:0] AGE_EVICT = 32'd10;

    localparam logic [1:0] FN_ACQUIRE = 2'd0;
    localparam logic [1:0] FN_RELEASE = 2'd1;
    localparam logic [1:0] FN_FRAME   = 2'd2;
    localparam logic [1:0] FN_CLEANUP = 2'd3;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_CREATED = 2'd1;
    localparam logic [1:0] ST_LIMIT   = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    localparam logic [1:0] CLS_DYNAMIC = 2'd1;
    localparam logic [1:0] CLS_BAD     = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] req_size;
        logic [1:0]  req_target;
        logic [1:0]  usage_class;
        logic [6:0]  buffer_id;
        logic [31:0] unused_frames;
    } in_item_t;

    typedef struct packed {
        logic [6:0]       result_id;
        logic [1:0]       status;
        logic             over_limit;
        logic [MEM_W-1:0] total_memory;
        logic [MEM_W-1:0] active_memory;
        logic [6:0]       total_buffers;
        logic [6:0]       active_buffers;
        logic [31:0]      acquire_count;
        logic [31:0]      reuse_count;
        logic [31:0]      create_count;
        logic [31:0]      release_count;
        logic [31:0]      frame_number;
    } out_item_t;

endpackage

// ----- rtl/best_fit_buffer_pool_core.sv -----
`timescale 1ns / 1ps
// Best-fit buffer pool: slot table, sequencer and statistics.
// Depends on bfp_pkg.
//
// Input channel in_valid/in_stall/in_data carries one request item; output
// channel out_valid/out_stall/out_data returns one result item per request.
// memory_limit is written over cfg_valid/cfg_ready/cfg_data (always ready);
// the user must write it only while the block is idle; the block does not enforce it.
// One item is processed at a time; in_stall is high until its result has
// been loaded into the output register. Release reads the slot, then
// updates it; new frame goes straight to the output; cleanup runs one
// eviction pass; acquire runs a best-fit pass, after an eviction pass when
// the limit forces one. One shared scan steps through the slot memory one entry a cycle.
// The output register holds a result while out_stall is high; a finished
// item waits in its last state until the register is free.
// Reset empties the table and clears counters, frame and limit; no clearing
// pass is needed, slot validity lives in flip-flops.
module best_fit_buffer_pool_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  bfp_pkg::in_item_t  in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output bfp_pkg::out_item_t out_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [37:0]      cfg_data
);
    import bfp_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EVSC  = 3'd1;
    localparam logic [2:0] S_EVCHK = 3'd2;
    localparam logic [2:0] S_FIT   = 3'd3;
    localparam logic [2:0] S_ALLOC = 3'd4;
    localparam logic [2:0] S_RELRD = 3'd5;
    localparam logic [2:0] S_REL   = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    localparam int MA_W = 32 + 2 + 2 + 32;

    logic [2:0]         state_reg;
    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] busy_reg;
    logic [MEM_W-1:0]   limit_reg;
    logic [MEM_W-1:0]   tot_reg;
    logic [MEM_W-1:0]   act_reg;
    logic [CNT_W-1:0]   ntot_reg;
    logic [CNT_W-1:0]   nact_reg;
    logic [31:0]        acq_cnt_reg;
    logic [31:0]        reu_cnt_reg;
    logic [31:0]        cre_cnt_reg;
    logic [31:0]        rel_cnt_reg;
    logic [31:0]        frame_reg;
    logic [31:0]        order_reg;

    logic [31:0]        size_reg;
    logic [1:0]         tgt_reg;
    logic [1:0]         cls_reg;
    logic [31:0]        min_age_reg;
    logic [IDX_W-1:0]   rel_idx_reg;
    logic               acq_reg;

    logic [IDX_W:0]     cnt_reg;
    logic               p_vld_reg;
    logic [IDX_W-1:0]   p_idx_reg;

    logic               best_found_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    logic [31:0]        best_diff_reg;
    logic [31:0]        best_age_reg;
    logic               free_found_reg;
    logic [IDX_W-1:0]   free_idx_reg;

    logic [6:0]         rid_reg;
    logic [1:0]         status_reg;
    logic               over_reg;

    logic               out_valid_reg;
    out_item_t          out_reg;

    logic [MA_W-1:0]    mem_a [ENTRIES];
    logic [31:0]        mem_b [ENTRIES];
    logic [MA_W-1:0]    rd_a_reg;
    logic [31:0]        rd_b_reg;
    logic [IDX_W-1:0]   rd_addr;
    logic               wa_en;
    logic               wb_en;
    logic [IDX_W-1:0]   wb_addr;

    logic [31:0]        r_size;
    logic [1:0]         r_tgt;
    logic [1:0]         r_cls;
    logic [31:0]        r_order;
    logic               idle_slot;
    logic               ev_hit;
    logic [31:0]        diff;
    logic [31:0]        age_ord;
    logic               fit_hit;
    logic               better;
    logic [38:0]        need;
    logic               id_ok;
    logic               out_free;
    logic [1:0]         in_cls;
    logic [38:0]        in_need;

    assign r_size  = rd_a_reg[MA_W-1 -: 32];
    assign r_tgt   = rd_a_reg[35:34];
    assign r_cls   = rd_a_reg[33:32];
    assign r_order = rd_a_reg[31:0];

    assign idle_slot = p_vld_reg && valid_reg[p_idx_reg] && !busy_reg[p_idx_reg];
    assign ev_hit    = idle_slot && ((frame_reg - rd_b_reg) >= min_age_reg);
    assign diff      = r_size - size_reg;
    assign age_ord   = order_reg - r_order;
    assign fit_hit   = idle_slot && (r_cls == cls_reg) && (r_tgt == tgt_reg)
                       && (r_size >= size_reg) && (diff <= size_reg);
    assign better    = !best_found_reg || (diff < best_diff_reg)
                       || ((diff == best_diff_reg) && (age_ord > best_age_reg));
    assign need      = {1'b0, tot_reg} + 39'(size_reg);
    assign in_need   = {1'b0, tot_reg} + 39'(in_data.req_size);
    assign in_cls    = (in_data.usage_class == CLS_BAD) ? CLS_DYNAMIC : in_data.usage_class;
    assign id_ok     = (in_data.buffer_id != 7'd0)
                       && (32'(in_data.buffer_id) <= 32'(ENTRIES));
    assign out_free  = !out_valid_reg || !out_stall;

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign rd_addr = (state_reg == S_RELRD) ? rel_idx_reg : cnt_reg[IDX_W-1:0];
    assign wa_en   = (state_reg == S_ALLOC) && !best_found_reg && free_found_reg;
    assign wb_en   = (state_reg == S_ALLOC) && (best_found_reg || free_found_reg);
    assign wb_addr = best_found_reg ? best_idx_reg : free_idx_reg;

    always_ff @(posedge clk)
    begin
        if (wa_en)
        begin
            mem_a[free_idx_reg] <= {size_reg, tgt_reg, cls_reg, order_reg};
        end
        if (wb_en)
        begin
            mem_b[wb_addr] <= frame_reg;
        end
        rd_a_reg <= mem_a[rd_addr];
        rd_b_reg <= mem_b[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            valid_reg      <= '0;
            busy_reg       <= '0;
            limit_reg      <= '0;
            tot_reg        <= '0;
            act_reg        <= '0;
            ntot_reg       <= '0;
            nact_reg       <= '0;
            acq_cnt_reg    <= '0;
            reu_cnt_reg    <= '0;
            cre_cnt_reg    <= '0;
            rel_cnt_reg    <= '0;
            frame_reg      <= '0;
            order_reg      <= '0;
            cnt_reg        <= '0;
            p_vld_reg      <= 1'b0;
            best_found_reg <= 1'b0;
            free_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
            if (out_valid_reg && !out_stall && (state_reg != S_OUT))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        size_reg    <= in_data.req_size;
                        tgt_reg     <= in_data.req_target;
                        cls_reg     <= in_cls;
                        rel_idx_reg <= IDX_W'(32'(in_data.buffer_id) - 32'd1);
                        acq_reg     <= (in_data.func == FN_ACQUIRE);
                        rid_reg     <= '0;
                        status_reg  <= ST_DONE;
                        over_reg    <= 1'b0;
                        cnt_reg     <= '0;
                        p_vld_reg   <= 1'b0;
                        best_found_reg <= 1'b0;
                        free_found_reg <= 1'b0;
                        case (in_data.func)
                            FN_ACQUIRE:
                            begin
                                acq_cnt_reg <= acq_cnt_reg + 32'd1;
                                min_age_reg <= AGE_EVICT;
                                if ((limit_reg != '0) && (in_need > {1'b0, limit_reg}))
                                begin
                                    state_reg <= S_EVSC;
                                end
                                else
                                begin
                                    state_reg <= S_FIT;
                                end
                            end
                            FN_RELEASE:
                            begin
                                state_reg <= id_ok ? S_RELRD : S_OUT;
                            end
                            FN_FRAME:
                            begin
                                busy_reg  <= '0;
                                act_reg   <= '0;
                                nact_reg  <= '0;
                                frame_reg <= frame_reg + 32'd1;
                                state_reg <= S_OUT;
                            end
                            default:
                            begin
                                min_age_reg <= in_data.unused_frames;
                                state_reg   <= S_EVSC;
                            end
                        endcase
                    end
                end
                S_EVSC:
                begin
                    p_vld_reg <= (cnt_reg < (IDX_W + 1)'(ENTRIES));
                    p_idx_reg <= cnt_reg[IDX_W-1:0];
                    if (cnt_reg != (IDX_W + 1)'(ENTRIES))
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    if (ev_hit)
                    begin
                        valid_reg[p_idx_reg] <= 1'b0;
                        tot_reg  <= tot_reg - MEM_W'(r_size);
                        ntot_reg <= ntot_reg - 1'b1;
                    end
                    if (cnt_reg == (IDX_W + 1)'(ENTRIES))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= acq_reg ? S_EVCHK : S_OUT;
                    end
                end
                S_EVCHK:
                begin
                    if (need > {1'b0, limit_reg})
                    begin
                        status_reg <= ST_LIMIT;
                        state_reg  <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_FIT;
                    end
                end
                S_FIT:
                begin
                    p_vld_reg <= (cnt_reg < (IDX_W + 1)'(ENTRIES));
                    p_idx_reg <= cnt_reg[IDX_W-1:0];
                    if (cnt_reg != (IDX_W + 1)'(ENTRIES))
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    if (fit_hit && better)
                    begin
                        best_found_reg <= 1'b1;
                        best_idx_reg   <= p_idx_reg;
                        best_diff_reg  <= diff;
                        best_age_reg   <= age_ord;
                    end
                    if (p_vld_reg && !valid_reg[p_idx_reg] && !free_found_reg)
                    begin
                        free_found_reg <= 1'b1;
                        free_idx_reg   <= p_idx_reg;
                    end
                    if (cnt_reg == (IDX_W + 1)'(ENTRIES))
                    begin
                        state_reg <= S_ALLOC;
                    end
                end
                S_ALLOC:
                begin
                    if (best_found_reg)
                    begin
                        busy_reg[best_idx_reg] <= 1'b1;
                        reu_cnt_reg <= reu_cnt_reg + 32'd1;
                        act_reg     <= act_reg + MEM_W'(best_diff_reg) + MEM_W'(size_reg);
                        nact_reg    <= nact_reg + 1'b1;
                        rid_reg     <= 7'(32'(best_idx_reg) + 32'd1);
                    end
                    else if (free_found_reg)
                    begin
                        valid_reg[free_idx_reg] <= 1'b1;
                        busy_reg[free_idx_reg]  <= 1'b1;
                        order_reg   <= order_reg + 32'd1;
                        cre_cnt_reg <= cre_cnt_reg + 32'd1;
                        tot_reg     <= need[MEM_W-1:0];
                        act_reg     <= act_reg + MEM_W'(size_reg);
                        ntot_reg    <= ntot_reg + 1'b1;
                        nact_reg    <= nact_reg + 1'b1;
                        rid_reg     <= 7'(32'(free_idx_reg) + 32'd1);
                        status_reg  <= ST_CREATED;
                        over_reg    <= (limit_reg != '0) && (need > {1'b0, limit_reg});
                    end
                    else
                    begin
                        status_reg <= ST_FULL;
                    end
                    state_reg <= S_OUT;
                end
                S_RELRD:
                begin
                    state_reg <= S_REL;
                end
                S_REL:
                begin
                    if (valid_reg[rel_idx_reg])
                    begin
                        if (busy_reg[rel_idx_reg])
                        begin
                            act_reg  <= act_reg - MEM_W'(r_size);
                            nact_reg <= nact_reg - 1'b1;
                        end
                        busy_reg[rel_idx_reg] <= 1'b0;
                        rel_cnt_reg <= rel_cnt_reg + 32'd1;
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg          <= 1'b1;
                        out_reg.result_id      <= rid_reg;
                        out_reg.status         <= status_reg;
                        out_reg.over_limit     <= over_reg;
                        out_reg.total_memory   <= tot_reg;
                        out_reg.active_memory  <= act_reg;
                        out_reg.total_buffers  <= 7'(ntot_reg);
                        out_reg.active_buffers <= 7'(nact_reg);
                        out_reg.acquire_count  <= acq_cnt_reg;
                        out_reg.reuse_count    <= reu_cnt_reg;
                        out_reg.create_count   <= cre_cnt_reg;
                        out_reg.release_count  <= rel_cnt_reg;
                        out_reg.frame_number   <= frame_reg;
                        state_reg              <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- rtl/bfp_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the buffer pool, bound to the top level.
// Depends on bfp_pkg and best_fit_buffer_pool_core.
module bfp_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input bfp_pkg::out_item_t out_data
);
    import bfp_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result item dropped or changed under stall");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second item taken while one is in work");

    a_fail_no_id: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.status != ST_LIMIT && out_data.status != ST_FULL)
                      || out_data.result_id == 7'd0)
        else $error("failed acquire returned an id");

    a_counts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.active_buffers <= out_data.total_buffers
                      && out_data.active_memory <= out_data.total_memory)
        else $error("active statistics exceed totals");

    a_over_created: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.over_limit |-> out_data.status == ST_CREATED)
        else $error("over-limit flag without a creation");

endmodule

bind best_fit_buffer_pool_core bfp_checker u_bfp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
